// File: rtl/bracket_balance_checker_defines.svh
// Assertion macros for the bracket balance checker.
// No dependencies; included by the checker file.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bbc_pkg.sv
// Shared types, constants and the bracket decoder for the bracket balance checker.
// No dependencies.
package bbc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = 24;
  localparam int NEST_W      = 11;
  localparam int CHAR_W      = 8;
  localparam int OP_W        = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LSQR   = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQR   = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LCURL  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURL  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;

  typedef enum logic [OP_W-1:0] {
    OP_CHAR  = 2'd0,
    OP_EOL   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CODE_PAREN  = 2'd0,
    CODE_SQUARE = 2'd1,
    CODE_CURLY  = 2'd2
  } code_t;

  typedef struct packed {
    logic  hit;
    logic  opener;
    code_t code;
  } bracket_t;

  function automatic bracket_t decode_bracket(input logic [CHAR_W-1:0] c);
    bracket_t b;
    b = '{hit: 1'b1, opener: 1'b1, code: CODE_PAREN};
    unique case (c)
      CH_LPAREN: b.code = CODE_PAREN;
      CH_LSQR:   b.code = CODE_SQUARE;
      CH_LCURL:  b.code = CODE_CURLY;
      CH_RPAREN: begin
        b.opener = 1'b0;
        b.code   = CODE_PAREN;
      end
      CH_RSQR: begin
        b.opener = 1'b0;
        b.code   = CODE_SQUARE;
      end
      CH_RCURL: begin
        b.opener = 1'b0;
        b.code   = CODE_CURLY;
      end
      default: begin
        b.hit    = 1'b0;
        b.opener = 1'b0;
      end
    endcase
    return b;
  endfunction

endpackage

// File: rtl/bbc_if.sv
// Request channel interfaces for the bracket balance checker.
// Depends on bbc_pkg for field widths.
interface bbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bbc_pkg::OP_W-1:0]   op;
  logic [bbc_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface bbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbc_pkg::COUNT_W-1:0] bracket_count;
  logic [bbc_pkg::NEST_W-1:0]  nesting_depth;
  logic                        error_seen;
  logic                        text_valid;

  modport source (output valid, output bracket_count, output nesting_depth,
                  output error_seen, output text_valid, input ready);
  modport sink   (input valid, input bracket_count, input nesting_depth,
                  input error_seen, input text_valid, output ready);
endinterface

// File: rtl/bracket_balance_checker.sv
// Bracket balance checker top level: lexer flags, opener stack and result register.
// Depends on bbc_pkg and the channel interfaces in bbc_if.sv.
//
// Each request (a text byte, a line end, a clear, or an idle) yields exactly one result,
// registered, in the cycle after it is taken; a new request is taken every clock,
// including while a result waits, as long as that result is being taken in the
// same cycle. The rate is set by the state update: the top of the
// opener stack sits in a flop, and the entry below it is read from the stack RAM
// every cycle (with write forwarding), so a closer right after a push or pop
// still sees the right top. The stack RAM is not cleared on reset or clear; only
// entries below the current depth are ever used, so no clearing pass is needed.
module bracket_balance_checker (
  input  logic       clk,
  input  logic       rst,
  bbc_in_if.sink     text_in,
  bbc_out_if.source  result_out
);

  // State
  logic [bbc_pkg::DEPTH_W-1:0] depth, depth_next;
  logic [bbc_pkg::COUNT_W-1:0] count, count_next;
  logic                        err, err_next;
  logic                        in_str, in_str_next;
  logic                        in_blk, in_blk_next;
  logic                        in_line, in_line_next;
  logic                        slash_p, slash_p_next;
  logic                        star_p, star_p_next;
  bbc_pkg::code_t              top_code, top_code_next;
  bbc_pkg::code_t              below_code;

  // Stack RAM holds every entry under the top
  bbc_pkg::code_t              stack_mem [bbc_pkg::STACK_DEPTH];
  logic                        mem_we;
  logic [bbc_pkg::ADDR_W-1:0]  mem_waddr;
  logic [bbc_pkg::ADDR_W-1:0]  mem_raddr;
  logic [bbc_pkg::DEPTH_W-1:0] raddr_full;

  logic                        accept;
  logic                        handled;
  logic [bbc_pkg::CHAR_W-1:0]  c;
  bbc_pkg::bracket_t           br;

  assign text_in.ready = !rst && (!result_out.valid || result_out.ready);
  assign accept        = text_in.valid && text_in.ready;
  assign c             = text_in.char_code;
  assign br            = bbc_pkg::decode_bracket(c);

  // Next state
  always_comb begin
    depth_next    = depth;
    count_next    = count;
    err_next      = err;
    in_str_next   = in_str;
    in_blk_next   = in_blk;
    in_line_next  = in_line;
    slash_p_next  = slash_p;
    star_p_next   = star_p;
    top_code_next = top_code;
    mem_we        = 1'b0;
    mem_waddr     = bbc_pkg::ADDR_W'(depth - bbc_pkg::DEPTH_W'(1));
    handled       = 1'b0;
    if (accept) begin
      unique case (bbc_pkg::op_t'(text_in.op))
        bbc_pkg::OP_CHAR: begin
          priority if (in_line) begin
            // rest of line is comment
          end else if (in_blk) begin
            if (star_p && c == bbc_pkg::CH_SLASH) begin
              in_blk_next = 1'b0;
              star_p_next = 1'b0;
            end else begin
              star_p_next = (c == bbc_pkg::CH_STAR);
            end
          end else if (in_str) begin
            if (c == bbc_pkg::CH_QUOTE) in_str_next = 1'b0;
          end else begin
            // a pending slash resolves on this byte
            if (slash_p) begin
              slash_p_next = 1'b0;
              if (c == bbc_pkg::CH_SLASH) begin
                in_line_next = 1'b1;
                handled      = 1'b1;
              end else if (c == bbc_pkg::CH_STAR) begin
                in_blk_next = 1'b1;
                star_p_next = 1'b0;
                handled     = 1'b1;
              end
            end
            if (!handled) begin
              priority if (c == bbc_pkg::CH_QUOTE) begin
                in_str_next = 1'b1;
              end else if (c == bbc_pkg::CH_SLASH) begin
                slash_p_next = 1'b1;
              end else if (br.hit) begin
                if (count != bbc_pkg::COUNT_MAX) count_next = count + bbc_pkg::COUNT_W'(1);
                if (br.opener) begin
                  if (depth >= bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH)) begin
                    err_next = 1'b1;
                  end else begin
                    // old top moves down into the RAM
                    mem_we        = (depth != '0);
                    top_code_next = br.code;
                    depth_next    = depth + bbc_pkg::DEPTH_W'(1);
                  end
                end else begin
                  if (depth == '0 || top_code != br.code) begin
                    err_next = 1'b1;
                  end else begin
                    top_code_next = below_code;
                    depth_next    = depth - bbc_pkg::DEPTH_W'(1);
                  end
                end
              end else begin
                // plain text byte
              end
            end
          end
        end
        bbc_pkg::OP_EOL: begin
          in_line_next = 1'b0;
          slash_p_next = 1'b0;
          star_p_next  = 1'b0;
        end
        bbc_pkg::OP_CLEAR: begin
          depth_next    = '0;
          count_next    = '0;
          err_next      = 1'b0;
          in_str_next   = 1'b0;
          in_blk_next   = 1'b0;
          in_line_next  = 1'b0;
          slash_p_next  = 1'b0;
          star_p_next   = 1'b0;
        end
        bbc_pkg::OP_IDLE: begin
          // no change
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch the entry that becomes top after a pop
  assign raddr_full = depth_next - bbc_pkg::DEPTH_W'(2);
  assign mem_raddr  = raddr_full[bbc_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= top_code;
    if (mem_we && mem_waddr == mem_raddr) below_code <= top_code;
    else                                  below_code <= stack_mem[mem_raddr];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      count    <= '0;
      err      <= 1'b0;
      in_str   <= 1'b0;
      in_blk   <= 1'b0;
      in_line  <= 1'b0;
      slash_p  <= 1'b0;
      star_p   <= 1'b0;
    end else begin
      depth    <= depth_next;
      count    <= count_next;
      err      <= err_next;
      in_str   <= in_str_next;
      in_blk   <= in_blk_next;
      in_line  <= in_line_next;
      slash_p  <= slash_p_next;
      star_p   <= star_p_next;
    end
  end

  always_ff @(posedge clk) begin
    top_code <= top_code_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.bracket_count <= count_next;
      result_out.nesting_depth <= bbc_pkg::NEST_W'(depth_next);
      result_out.error_seen    <= err_next;
      result_out.text_valid    <= !err_next && (depth_next == '0);
    end
  end

endmodule

// File: rtl/bbc_checker.sv
// Port-level assertions for the bracket balance checker, bound to the top level.
// Depends on bbc_pkg and the macros in bracket_balance_checker_defines.svh.
`include "bracket_balance_checker_defines.svh"

module bbc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [bbc_pkg::OP_W-1:0]    in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bbc_pkg::COUNT_W-1:0] bracket_count,
  input logic [bbc_pkg::NEST_W-1:0]  nesting_depth,
  input logic                        error_seen,
  input logic                        text_valid
);

  logic in_take;
  logic is_clear;

  assign in_take  = in_valid && in_ready;
  assign is_clear = (in_op == bbc_pkg::OP_CLEAR);

  // stalled result holds
  `BBC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(bracket_count) && $stable(nesting_depth) && $stable(error_seen), "result changed while stalled")

  // verdict agrees with error and depth
  `BBC_ASSERT_SAME(a_verdict, clk, rst, out_valid, text_valid == (!error_seen && nesting_depth == '0), "verdict inconsistent")

  // error stays set until a clear
  `BBC_ASSERT_NEXT(a_err_sticky, clk, rst, in_take && !is_clear && out_valid && error_seen, out_valid && error_seen, "error flag dropped without clear")

  // clear reports reset state
  `BBC_ASSERT_NEXT(a_clear, clk, rst, in_take && is_clear, out_valid && bracket_count == '0 && nesting_depth == '0 && !error_seen, "clear did not reset state")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (text_in.valid),
  .in_ready      (text_in.ready),
  .in_op         (text_in.op),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .bracket_count (result_out.bracket_count),
  .nesting_depth (result_out.nesting_depth),
  .error_seen    (result_out.error_seen),
  .text_valid    (result_out.text_valid)
);
